// ----- rtl/core/mme_pkg.sv -----
// Shared types and constants for the matrix multiply engine core.
// Request codes, register indexes, field widths and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package mme_pkg;

  // field widths fixed by the interface
  localparam int REQ_W     = 2;
  localparam int IDX_W     = 4;
  localparam int VALUE_W   = 16;
  localparam int PRODUCT_W = 36;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  // parameter defaults
  localparam int MAX_DIM_DEF    = 16;
  localparam int ELEM_WIDTH_DEF = 16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WR_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WR_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE_A = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] INNER_LEN_RST = 5'd16;
  localparam logic [CFG_W-1:0] OUT_ROWS_RST  = 5'd16;
  localparam logic [CFG_W-1:0] OUT_COLS_RST  = 5'd16;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic valid;  // operand pair on the store outputs is live
  } mac_ctrl_t;

endpackage

// ----- rtl/core/matrix_multiply_engine_core.sv -----
// Matrix multiply engine core: two element stores, sequencer, MAC and output register.
// Depends on mme_pkg, mme_store and mme_mac.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request word: write an
//   element of A, write an element of B, or read product element (row, col).
//   Output channel (out_valid_o/out_ready_i) returns exactly one word per
//   request: product and status. Writes answer zero/ok; a read outside
//   out_rows x out_cols answers zero with status 1.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); the
//   user must write it only while the core is idle, which the core does not enforce.
// Timing:
//   A write's answer sits in the output register in the cycle after the write
//   is taken. For a good read the sequencer issues one A/B address pair per
//   cycle to the stores, each store read is registered, the product is
//   registered, then accumulated in the single shared multiply-accumulate path.
//   A read is taken even while the previous answer waits in the output
//   register; writes wait for a free output slot.
// Reset: control and configuration registers return to defaults. Store
//   contents are undefined until written; no clearing pass.
// Stall: a held output word blocks the next answer, not the next read.
`timescale 1ns / 1ps

module matrix_multiply_engine_core #(
  parameter int MAX_DIM    = mme_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mme_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mme_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [mme_pkg::REQ_W-1:0]            req_type_i,
  input  logic [mme_pkg::IDX_W-1:0]            row_i,
  input  logic [mme_pkg::IDX_W-1:0]            col_i,
  input  logic signed [mme_pkg::VALUE_W-1:0]   value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [mme_pkg::PRODUCT_W-1:0] product_o,
  output logic                                 status_o
);
  import mme_pkg::*;

  localparam int StoreW = (ELEM_WIDTH < VALUE_W) ? ELEM_WIDTH : VALUE_W;
  localparam int Depth  = MAX_DIM * MAX_DIM;
  localparam int AddrW  = $clog2(Depth);
  localparam int IdxW   = $clog2(MAX_DIM);
  localparam int WideW  = IdxW + IDX_W;
  localparam int CmpW   = ((WideW > CFG_W) ? WideW : CFG_W) + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  function automatic logic [CmpW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CmpW-1:0] lim;
    lim = CmpW'(MAX_DIM);
    return (CmpW'(v) > lim) ? lim : CmpW'(v);
  endfunction

  // configuration
  logic [CFG_W-1:0] inner_len_q, out_rows_q, out_cols_q;
  logic             transpose_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_len_q <= INNER_LEN_RST;
      out_rows_q  <= OUT_ROWS_RST;
      out_cols_q  <= OUT_COLS_RST;
      transpose_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INNER_LEN:   inner_len_q <= cfg_data_i;
        CFG_OUT_ROWS:    out_rows_q  <= cfg_data_i;
        CFG_OUT_COLS:    out_cols_q  <= cfg_data_i;
        CFG_TRANSPOSE_A: transpose_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [1:0]         state_q, state_d;
  logic [IdxW-1:0]    k_q, k_d;
  logic [IdxW-1:0]    kl_q, kl_d;
  logic [IdxW-1:0]    row_q, row_d, col_q, col_d;
  logic               err_q, err_d;
  logic               rd_vld_q;
  logic               out_valid_q, out_valid_d;
  logic signed [PRODUCT_W-1:0] product_q, product_d;
  logic               status_q, status_d;

  logic               in_acc, slot_free, issue, out_load;
  logic               wr_in_range, store_a_we, store_b_we;
  logic [WideW-1:0]   row_wide, col_wide;
  logic [CmpW-1:0]    n_c, kl_c;
  logic               rd_err;
  logic [AddrW-1:0]   waddr, l_raddr, r_raddr;
  logic [StoreW-1:0]  l_rdata, r_rdata;
  mac_ctrl_t          mac_ctrl;
  logic signed [PRODUCT_W-1:0] acc;
  logic               mac_busy;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && (slot_free || req_type_i == REQ_READ);
  assign in_acc     = in_valid_i && in_ready_o;

  assign row_wide = WideW'(row_i);
  assign col_wide = WideW'(col_i);

  assign wr_in_range = (row_wide < WideW'(MAX_DIM)) && (col_wide < WideW'(MAX_DIM));
  assign waddr       = AddrW'(row_wide) * AddrW'(MAX_DIM) + AddrW'(col_wide);
  assign store_a_we  = in_acc && (req_type_i == REQ_WR_A) && wr_in_range;
  assign store_b_we  = in_acc && (req_type_i == REQ_WR_B) && wr_in_range;

  assign n_c    = clamp_dim(inner_len_q);
  assign kl_c   = n_c - CmpW'(1);
  assign rd_err = (CmpW'(row_i) >= clamp_dim(out_rows_q)) ||
                  (CmpW'(col_i) >= clamp_dim(out_cols_q));

  assign issue = (state_q == ST_RUN);

  // left operand walks row of A, or column of A when transposed
  assign l_raddr = transpose_q ? AddrW'(k_q) * AddrW'(MAX_DIM) + AddrW'(row_q)
                               : AddrW'(row_q) * AddrW'(MAX_DIM) + AddrW'(k_q);
  assign r_raddr = AddrW'(k_q) * AddrW'(MAX_DIM) + AddrW'(col_q);

  assign mac_ctrl.clear = in_acc && (req_type_i == REQ_READ);
  assign mac_ctrl.valid = rd_vld_q;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    kl_d        = kl_q;
    row_d       = row_q;
    col_d       = col_q;
    err_d       = err_q;
    out_load    = 1'b0;
    product_d   = product_q;
    status_d    = status_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (req_type_i == REQ_READ) begin
            row_d = row_wide[IdxW-1:0];
            col_d = col_wide[IdxW-1:0];
            k_d   = '0;
            kl_d  = kl_c[IdxW-1:0];
            err_d = rd_err;
            // error or empty sum skips the walk
            state_d = (rd_err || n_c == '0) ? ST_DRAIN : ST_RUN;
          end else begin
            out_load  = 1'b1;
            product_d = '0;
            status_d  = 1'b0;
          end
        end
      end
      ST_RUN: begin
        k_d = k_q + IdxW'(1);
        if (k_q == kl_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !mac_busy && slot_free) begin
          out_load  = 1'b1;
          product_d = err_q ? '0 : acc;
          status_d  = err_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      kl_q        <= '0;
      err_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      kl_q        <= kl_d;
      err_q       <= err_d;
      rd_vld_q    <= issue;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q     <= row_d;
    col_q     <= col_d;
    product_q <= product_d;
    status_q  <= status_d;
  end

  mme_store #(
    .Depth (Depth),
    .AddrW (AddrW),
    .DataW (StoreW)
  ) u_left_store (
    .clk_i   (clk_i),
    .we_i    (store_a_we),
    .waddr_i (waddr),
    .wdata_i (value_i[StoreW-1:0]),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  mme_store #(
    .Depth (Depth),
    .AddrW (AddrW),
    .DataW (StoreW)
  ) u_right_store (
    .clk_i   (clk_i),
    .we_i    (store_b_we),
    .waddr_i (waddr),
    .wdata_i (value_i[StoreW-1:0]),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  mme_mac #(
    .DataW (StoreW)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    ($signed(l_rdata)),
    .b_i    ($signed(r_rdata)),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  assign out_valid_o = out_valid_q;
  assign product_o   = product_q;
  assign status_o    = status_q;

  // MAC pipeline is empty whenever the sequencer is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !rd_vld_q && !mac_busy)
    else $error("MAC pipeline busy while idle");

  // store data is only marked live after an issue cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == ST_RUN)
    else $error("read data valid without issue");

  // walk index never passes the last term
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> k_q <= kl_q)
    else $error("inner index overran");

  // an error word carries a zero product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> product_o == '0)
    else $error("error word with nonzero product");

endmodule

// ----- rtl/core/mme_store.sv -----
// Element store: single write port, one synchronous read port (registered read data).
// Holds one matrix, entry row*MAX_DIM+col. Uses no package items.
`timescale 1ns / 1ps

module mme_store #(
  parameter int Depth = 256,
  parameter int AddrW = 8,
  parameter int DataW = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/mme_mac.sv -----
// Multiply-accumulate unit: registered product, then wrapping wide accumulate.
// Depends on mme_pkg (PRODUCT_W, mac_ctrl_t).
`timescale 1ns / 1ps

module mme_mac #(
  parameter int DataW = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mme_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [DataW-1:0]             a_i,
  input  logic signed [DataW-1:0]             b_i,
  output logic signed [mme_pkg::PRODUCT_W-1:0] acc_o,
  output logic                                busy_o
);
  import mme_pkg::*;

  localparam int ProdW = 2 * DataW;

  logic                        prod_vld_q;
  logic signed [ProdW-1:0]     prod_q;
  logic signed [PRODUCT_W-1:0] prod_ext;
  logic signed [PRODUCT_W-1:0] acc_q, acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_ext = {{(PRODUCT_W - ProdW){prod_q[ProdW-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + prod_ext;  // wraps modulo 2^PRODUCT_W
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_vld_q;

endmodule

// ----- dv/tb.sv -----
// Self-checking bench for matrix_multiply_engine_core: a directed table, then random
// element writes, product reads and unused request codes, checked against an in-bench
// dot-product predictor. Depends on mme_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import mme_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int DIM         = MAX_DIM_DEF;
  localparam int SETTLE_CYC  = DIM + 8;   // enough for a full-length read, with margin
  localparam int HOLD_CYC    = 200;
  localparam int PHASE_ITEMS = 83;
  localparam int NUM_PHASES  = 10;

  typedef struct packed {
    logic signed [PRODUCT_W-1:0] product;
    logic                        status;
  } answer_t;

  typedef struct packed {
    logic [REQ_W-1:0]            req;
    logic [IDX_W-1:0]            row;
    logic [IDX_W-1:0]            col;
    logic [VALUE_W-1:0]          value;
    logic                        fixed;   // answer typed in, not predicted
    logic signed [PRODUCT_W-1:0] exp_product;
    logic                        exp_status;
  } dir_row_t;

  logic                        clk_i;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx_i   = '0;
  logic [CFG_W-1:0]            cfg_data_i  = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic [REQ_W-1:0]            req_type_i  = '0;
  logic [IDX_W-1:0]            row_i       = '0;
  logic [IDX_W-1:0]            col_i       = '0;
  logic signed [VALUE_W-1:0]   value_i     = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [PRODUCT_W-1:0] product_o;
  logic                        status_o;

  matrix_multiply_engine_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .product_o   (product_o),
    .status_o    (status_o)
  );

  // predictor state: element stores, written flags, register copies
  logic signed [VALUE_W-1:0] a_elem [DIM*DIM];
  logic signed [VALUE_W-1:0] b_elem [DIM*DIM];
  bit                        a_set  [DIM*DIM];
  bit                        b_set  [DIM*DIM];
  logic [CFG_W-1:0]          inner_len_q = INNER_LEN_RST;
  logic [CFG_W-1:0]          out_rows_q  = OUT_ROWS_RST;
  logic [CFG_W-1:0]          out_cols_q  = OUT_COLS_RST;
  logic                      transpose_q = 1'b0;

  answer_t pending_answers [$];
  int      errors      = 0;
  int      n_writes    = 0;
  int      n_good_rd   = 0;
  int      n_bad_rd    = 0;
  int      n_unused    = 0;
  int      n_settings  = 0;
  bit      tx_idle     = 1'b1;
  bit      rx_idle     = 1'b1;
  bit      hold_req    = 1'b0;
  int      n_holds     = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int clamp_dim(logic [CFG_W-1:0] v);
    return (v > DIM) ? DIM : int'(v);
  endfunction

  // applies one request to the predictor state and returns its answer
  function automatic answer_t compute_answer(logic [REQ_W-1:0] req, logic [IDX_W-1:0] row,
                                             logic [IDX_W-1:0] col,
                                             logic signed [VALUE_W-1:0] value);
    answer_t                     ans;
    logic signed [PRODUCT_W-1:0] acc;
    logic signed [2*VALUE_W-1:0] term;
    int                          k;
    int                          la;
    ans = '0;
    case (req)
      REQ_WR_A: begin
        a_elem[row*DIM + col] = value;
        a_set[row*DIM + col]  = 1'b1;
      end
      REQ_WR_B: begin
        b_elem[row*DIM + col] = value;
        b_set[row*DIM + col]  = 1'b1;
      end
      REQ_READ: begin
        if (row >= clamp_dim(out_rows_q) || col >= clamp_dim(out_cols_q)) begin
          ans.status = 1'b1;
        end else begin
          acc = '0;
          for (k = 0; k < clamp_dim(inner_len_q); k++) begin
            la   = transpose_q ? k*DIM + row : row*DIM + k;
            term = a_elem[la] * b_elem[k*DIM + col];
            acc  = acc + PRODUCT_W'(term);
          end
          ans.product = acc;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // first entry a read would touch that was never written: -1 if none,
  // else the A address, or DIM*DIM plus the B address
  function automatic int find_unset(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
    int k;
    int la;
    if (row >= clamp_dim(out_rows_q) || col >= clamp_dim(out_cols_q)) return -1;
    for (k = 0; k < clamp_dim(inner_len_q); k++) begin
      la = transpose_q ? k*DIM + row : row*DIM + k;
      if (!a_set[la]) return la;
      if (!b_set[k*DIM + col]) return DIM*DIM + k*DIM + col;
    end
    return -1;
  endfunction

  function automatic logic [VALUE_W-1:0] draw_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic signed [PRODUCT_W-1:0] got,
                                 logic signed [PRODUCT_W-1:0] want);
    errors++;
    if (errors <= 40) $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
  endtask

  task automatic send_word(logic [REQ_W-1:0] req, logic [IDX_W-1:0] row,
                           logic [IDX_W-1:0] col, logic [VALUE_W-1:0] value,
                           bit fixed, answer_t fixed_ans);
    int      gap;
    answer_t ans;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    row_i      <= row;
    col_i      <= col;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    ans = compute_answer(req, row, col, value);
    pending_answers.push_back(fixed ? fixed_ans : ans);
    if (req == REQ_READ) begin
      if (ans.status) n_bad_rd++;
      else n_good_rd++;
    end else if (req == REQ_UNUSED) begin
      n_unused++;
    end else begin
      n_writes++;
    end
  endtask

  // drop valid and wait until every answer is back
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_INNER_LEN:   inner_len_q = data;
      CFG_OUT_ROWS:    out_rows_q  = data;
      CFG_OUT_COLS:    out_cols_q  = data;
      CFG_TRANSPOSE_A: transpose_q = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [CFG_W-1:0] il, logic [CFG_W-1:0] rows,
                            logic [CFG_W-1:0] cols, logic tr);
    write_reg(CFG_INNER_LEN, il);
    write_reg(CFG_OUT_ROWS, rows);
    write_reg(CFG_OUT_COLS, cols);
    // upper bits of the transpose word are don't-care
    write_reg(CFG_TRANSPOSE_A, {4'($urandom), tr});
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic random_item();
    int               pick;
    int               miss;
    int               rd;
    int               cd;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    pick = $urandom_range(0, 99);
    row  = IDX_W'($urandom);
    col  = IDX_W'($urandom);
    if (pick < 5) begin
      send_word(REQ_UNUSED, row, col, draw_value(), 1'b0, '0);
    end else if (pick < 40) begin
      send_word((pick < 22) ? REQ_WR_A : REQ_WR_B, row, col, draw_value(), 1'b0, '0);
    end else begin
      rd = clamp_dim(out_rows_q);
      cd = clamp_dim(out_cols_q);
      // mostly aim inside the product, sometimes anywhere
      if ($urandom_range(0, 3) != 0) begin
        row = IDX_W'($urandom_range(0, (rd > 0) ? rd - 1 : 0));
        col = IDX_W'($urandom_range(0, (cd > 0) ? cd - 1 : 0));
      end
      miss = find_unset(row, col);
      if (miss < 0) begin
        send_word(REQ_READ, row, col, draw_value(), 1'b0, '0);
      end else begin
        // write the missing operand instead of reading
        send_word((miss >= DIM*DIM) ? REQ_WR_B : REQ_WR_A,
                  IDX_W'((miss % (DIM*DIM)) / DIM), IDX_W'(miss % DIM),
                  draw_value(), 1'b0, '0);
      end
    end
  endtask

  initial begin : answer_side
    answer_t want;
    int      stall;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYC;
        hold_req = 1'b0;
        n_holds++;
      end else begin
        stall = rx_idle ? $urandom_range(0, 14) : 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected word", product_o, '0);
      end else begin
        want = pending_answers.pop_front();
        if (product_o !== want.product) report_mismatch("product", product_o, want.product);
        if (status_o !== want.status) begin
          report_mismatch("status", PRODUCT_W'(status_o), PRODUCT_W'(want.status));
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t dir_rows [19];
    answer_t  fixed_ans;
    int       phase;

    // inner_len 2, one product row, two product columns
    dir_rows[0]  = '{REQ_WR_A,   4'd0,  4'd0,  16'h7FFF, 1'b1, '0, 1'b0};
    dir_rows[1]  = '{REQ_WR_A,   4'd0,  4'd1,  16'h8000, 1'b1, '0, 1'b0};
    dir_rows[2]  = '{REQ_WR_B,   4'd0,  4'd0,  16'h8000, 1'b1, '0, 1'b0};
    dir_rows[3]  = '{REQ_WR_B,   4'd1,  4'd0,  16'h8000, 1'b1, '0, 1'b0};
    dir_rows[4]  = '{REQ_WR_B,   4'd0,  4'd1,  16'h7FFF, 1'b1, '0, 1'b0};
    dir_rows[5]  = '{REQ_WR_B,   4'd1,  4'd1,  16'h0001, 1'b1, '0, 1'b0};
    dir_rows[6]  = '{REQ_READ,   4'd0,  4'd0,  16'h0000, 1'b0, '0, 1'b0};
    dir_rows[7]  = '{REQ_READ,   4'd0,  4'd1,  16'hFFFF, 1'b0, '0, 1'b0};
    // reads outside the product size
    dir_rows[8]  = '{REQ_READ,   4'd1,  4'd0,  16'h1234, 1'b1, '0, 1'b1};
    dir_rows[9]  = '{REQ_READ,   4'd0,  4'd2,  16'h0000, 1'b1, '0, 1'b1};
    dir_rows[10] = '{REQ_READ,   4'd15, 4'd15, 16'hFFFF, 1'b1, '0, 1'b1};
    dir_rows[11] = '{REQ_UNUSED, 4'd15, 4'd15, 16'hFFFF, 1'b1, '0, 1'b0};
    dir_rows[12] = '{REQ_WR_A,   4'd15, 4'd15, 16'hFFFF, 1'b1, '0, 1'b0};
    dir_rows[13] = '{REQ_WR_B,   4'd15, 4'd15, 16'h0000, 1'b1, '0, 1'b0};
    dir_rows[14] = '{REQ_WR_A,   4'd0,  4'd1,  16'h7FFF, 1'b1, '0, 1'b0};
    dir_rows[15] = '{REQ_READ,   4'd0,  4'd0,  16'h0000, 1'b0, '0, 1'b0};
    // most negative squared, twice
    dir_rows[16] = '{REQ_WR_A,   4'd0,  4'd0,  16'h8000, 1'b1, '0, 1'b0};
    dir_rows[17] = '{REQ_WR_A,   4'd0,  4'd1,  16'h8000, 1'b1, '0, 1'b0};
    dir_rows[18] = '{REQ_READ,   4'd0,  4'd0,  16'h5A5A, 1'b0, '0, 1'b0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // transpose stays at its reset value here
    write_reg(CFG_INNER_LEN, 5'd2);
    write_reg(CFG_OUT_ROWS, 5'd1);
    write_reg(CFG_OUT_COLS, 5'd2);
    cfg_we_i <= 1'b0;
    foreach (dir_rows[i]) begin
      fixed_ans.product = dir_rows[i].exp_product;
      fixed_ans.status  = dir_rows[i].exp_status;
      send_word(dir_rows[i].req, dir_rows[i].row, dir_rows[i].col, dir_rows[i].value,
                dir_rows[i].fixed, fixed_ans);
    end
    settle();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: set_config(5'd16, 5'd16, 5'd16, 1'b0);
        1: set_config(5'd31, 5'd31, 5'd31, 1'b1);
        2: set_config(5'd1,  5'd1,  5'd1,  1'b0);
        3: set_config(5'd0,  5'd16, 5'd16, 1'b1);
        4: set_config(5'd16, 5'd0,  5'd5,  1'b0);
        5: set_config(5'd3,  5'd16, 5'd0,  1'b1);
        6: set_config(5'd16, 5'd16, 5'd16, 1'b1);
        default: set_config(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                            1'($urandom));
      endcase
      tx_idle = (phase % 3) != 1;
      rx_idle = (phase % 4) != 2;
      if (phase == 6) begin
        // sender runs flat out while the output side holds off
        tx_idle  = 1'b0;
        hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) random_item();
      settle();
    end

    repeat (SETTLE_CYC) @(posedge clk_i);
    $display("Ran %0d element writes, %0d in-range reads, %0d out-of-range reads, %0d unused",
             n_writes, n_good_rd, n_bad_rd, n_unused);
    $display("codes, over %0d register settings with %0d long output stall(s)",
             n_settings, n_holds);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
